// ===== src/asc_pkg.sv =====
`default_nettype none

package asc_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int COUNT_BITS    = 16;
  localparam int MAG_BITS      = SAMPLE_BITS + 1;
  localparam int SUM_BITS      = 2 * MAG_BITS;
  localparam int PART_BITS     = SAMPLE_BITS + 2;
  localparam int REM_BITS      = MAG_BITS + 3;
  localparam int MUL_CNT_BITS  = $clog2(SAMPLE_BITS);
  localparam int ROOT_CNT_BITS = $clog2(MAG_BITS);
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = MAG_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_X_MEAN    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_Y_MEAN    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_Z_MEAN    = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd3;

  localparam logic [SAMPLE_BITS-1:0] MEAN_RESET      = SAMPLE_BITS'(512);
  localparam logic [MAG_BITS-1:0]    THRESHOLD_RESET = MAG_BITS'(80);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] x_sample;
    logic [SAMPLE_BITS-1:0] y_sample;
    logic [SAMPLE_BITS-1:0] z_sample;
  } in_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] step_count;
    logic                  step_detected;
    logic [MAG_BITS-1:0]   magnitude;
  } out_t;

endpackage

`default_nettype wire

// ===== src/asc_sqrt.sv =====
`default_nettype none

// Floor square root, two radicand bits in and one root bit out per cycle.
module asc_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [asc_pkg::SUM_BITS-1:0]  radicand,
  output logic                               done,
  output logic [asc_pkg::MAG_BITS-1:0]       root
);

  logic                                  busy;
  logic [asc_pkg::ROOT_CNT_BITS-1:0]     cnt;
  logic [asc_pkg::SUM_BITS-1:0]          rad;
  logic [asc_pkg::REM_BITS-1:0]          rem;
  logic [asc_pkg::REM_BITS-1:0]          rem_shift;
  logic [asc_pkg::REM_BITS-1:0]          trial;
  logic                                  take;

  assign rem_shift = {rem[asc_pkg::REM_BITS-3:0],
                      rad[asc_pkg::SUM_BITS-1:asc_pkg::SUM_BITS-2]};
  assign trial     = {1'b0, root, 2'b01};
  assign take      = (rem_shift >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start &&
              (cnt == asc_pkg::ROOT_CNT_BITS'(asc_pkg::MAG_BITS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[asc_pkg::SUM_BITS-3:0], 2'b00};
        if (take) begin
          rem  <= rem_shift - trial;
          root <= {root[asc_pkg::MAG_BITS-2:0], 1'b1};
        end else begin
          rem  <= rem_shift;
          root <= {root[asc_pkg::MAG_BITS-2:0], 1'b0};
        end
        if (cnt == asc_pkg::ROOT_CNT_BITS'(asc_pkg::MAG_BITS - 1)) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/accel_step_counter.sv =====
`default_nettype none

// Step counter for a three-axis accelerometer. Each item is one x/y/z sample;
// the calibrated means are subtracted, the deviations are squared and summed,
// and the floor square root is the magnitude. A step is counted when the sum
// of this and the previous magnitude rises above twice the threshold, and the
// detector re-arms once that sum falls below it. The count saturates. Each
// item gives one result. An accepted item passes through the bit-serial
// sum-of-squares unit (one multiplier bit per cycle for all three axes), the
// square root (one root bit per cycle) and a handoff to the output before the
// next item is accepted. The input is taken whenever the core is idle, even
// while the last result is still waiting on the output. Write the
// configuration registers only while the block is idle.
module accel_step_counter (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire asc_pkg::in_t                       in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output asc_pkg::out_t                           out_data,
  input  wire logic                               cfg_we,
  input  wire logic [asc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [asc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ROOT, S_HOLD} state_t;

  state_t                               state;
  logic [asc_pkg::SAMPLE_BITS-1:0]      x_mean, y_mean, z_mean;
  logic [asc_pkg::MAG_BITS-1:0]         step_threshold;
  logic [asc_pkg::MAG_BITS-1:0]         prev_mag;
  logic                                 above_flag;
  logic [asc_pkg::COUNT_BITS-1:0]       step_total;

  logic [asc_pkg::SAMPLE_BITS-1:0]      dx, dy, dz;
  logic [asc_pkg::SAMPLE_BITS-1:0]      mx, my, mz;
  logic [asc_pkg::SUM_BITS-1:0]         acc;
  logic [asc_pkg::MUL_CNT_BITS-1:0]     mul_cnt;
  logic                                 sq_start;
  logic                                 sq_done;
  logic [asc_pkg::MAG_BITS-1:0]         mag;

  logic [asc_pkg::PART_BITS-1:0]        partial;
  logic [asc_pkg::MAG_BITS:0]           pair_sum;
  logic [asc_pkg::MAG_BITS:0]           limit;
  logic                                 rise;
  logic [asc_pkg::COUNT_BITS-1:0]       step_total_next;
  logic                                 out_free;
  logic                                 accept;
  logic                                 finish;

  function automatic logic [asc_pkg::SAMPLE_BITS-1:0] abs_diff(
    input logic [asc_pkg::SAMPLE_BITS-1:0] a,
    input logic [asc_pkg::SAMPLE_BITS-1:0] b
  );
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  asc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (acc),
    .done     (sq_done),
    .root     (mag)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign finish   = ((state == S_ROOT && sq_done) || state == S_HOLD) && out_free;

  // MSB-first shift-and-add: one multiplier bit of each axis per cycle
  assign partial = asc_pkg::PART_BITS'(mx[asc_pkg::SAMPLE_BITS-1] ? dx : '0)
                 + asc_pkg::PART_BITS'(my[asc_pkg::SAMPLE_BITS-1] ? dy : '0)
                 + asc_pkg::PART_BITS'(mz[asc_pkg::SAMPLE_BITS-1] ? dz : '0);

  assign pair_sum = {1'b0, mag} + {1'b0, prev_mag};
  assign limit    = {step_threshold, 1'b0};
  assign rise     = (pair_sum > limit) && !above_flag;

  always_comb begin
    step_total_next = step_total;
    if (rise && (step_total != '1)) begin
      step_total_next = step_total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      sq_start       <= 1'b0;
      out_valid      <= 1'b0;
      mul_cnt        <= '0;
      x_mean         <= asc_pkg::MEAN_RESET;
      y_mean         <= asc_pkg::MEAN_RESET;
      z_mean         <= asc_pkg::MEAN_RESET;
      step_threshold <= asc_pkg::THRESHOLD_RESET;
      prev_mag       <= '0;
      above_flag     <= 1'b0;
      step_total     <= '0;
    end else begin
      sq_start  <= (state == S_MUL) &&
                   (mul_cnt == asc_pkg::MUL_CNT_BITS'(asc_pkg::SAMPLE_BITS - 1));
      out_valid <= finish || (out_valid && out_stall);

      if (cfg_we) begin
        unique case (cfg_index)
          asc_pkg::CFG_X_MEAN:    x_mean <= cfg_data[asc_pkg::SAMPLE_BITS-1:0];
          asc_pkg::CFG_Y_MEAN:    y_mean <= cfg_data[asc_pkg::SAMPLE_BITS-1:0];
          asc_pkg::CFG_Z_MEAN:    z_mean <= cfg_data[asc_pkg::SAMPLE_BITS-1:0];
          asc_pkg::CFG_THRESHOLD: step_threshold <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            dx      <= abs_diff(in_data.x_sample, x_mean);
            dy      <= abs_diff(in_data.y_sample, y_mean);
            dz      <= abs_diff(in_data.z_sample, z_mean);
            mx      <= abs_diff(in_data.x_sample, x_mean);
            my      <= abs_diff(in_data.y_sample, y_mean);
            mz      <= abs_diff(in_data.z_sample, z_mean);
            acc     <= '0;
            mul_cnt <= '0;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          acc <= {acc[asc_pkg::SUM_BITS-2:0], 1'b0} + asc_pkg::SUM_BITS'(partial);
          mx  <= {mx[asc_pkg::SAMPLE_BITS-2:0], 1'b0};
          my  <= {my[asc_pkg::SAMPLE_BITS-2:0], 1'b0};
          mz  <= {mz[asc_pkg::SAMPLE_BITS-2:0], 1'b0};
          if (mul_cnt == asc_pkg::MUL_CNT_BITS'(asc_pkg::SAMPLE_BITS - 1)) begin
            state <= S_ROOT;
          end else begin
            mul_cnt <= mul_cnt + 1'b1;
          end
        end
        S_ROOT, S_HOLD: begin
          // root stays stable in the sqrt unit until the next start
          if (sq_done || state == S_HOLD) begin
            if (out_free) begin
              out_data.step_count    <= step_total_next;
              out_data.step_detected <= rise;
              out_data.magnitude     <= mag;
              step_total             <= step_total_next;
              prev_mag               <= mag;
              if (pair_sum > limit) begin
                above_flag <= 1'b1;
              end else if (pair_sum < limit) begin
                above_flag <= 1'b0;
              end
              state <= S_IDLE;
            end else begin
              state <= S_HOLD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/asc_checker.sv =====
`default_nettype none

module asc_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire asc_pkg::out_t                      out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // core goes busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // a new result only comes out of work in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without an item in progress");

  a_detect_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.step_detected |-> out_data.step_count != '0)
    else $error("step detected with zero count");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not empty after reset");

endmodule

bind accel_step_counter asc_checker u_asc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
